// ===== rtl/core/gas_sensor_ppm_converter_assert.svh =====
// Assertion macros for the gas sensor ppm converter.
`ifndef GAS_SENSOR_PPM_CONVERTER_ASSERT_SVH
`define GAS_SENSOR_PPM_CONVERTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define GSPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GSPC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define GSPC_ASSERT(lbl, prop, msg)
`define GSPC_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/gspc_pkg.sv =====
// Shared constants, types and the exp2 root table of the gas sensor ppm converter.
`timescale 1ns / 1ps
`default_nettype none
package gspc_pkg;

	localparam int CALIB_SAMPLES = 100;
	localparam int GROUP_SAMPLES = 10;

	// serial divider geometry
	localparam int DIV_NW = 44;
	localparam int DIV_DW = 20;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		REG_SUPPLY  = 3'd0,
		REG_LOAD    = 3'd1,
		REG_RATIO   = 3'd2,
		REG_SLOPE   = 3'd3,
		REG_OFFSET  = 3'd4,
		REG_DIVIDER = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	// r_i = isqrt(r_(i-1) * 2^30), r_0 = 2^31; entry j holds r_(j+1) in Q30
	function automatic logic [15:0][31:0] root_table();
		logic [15:0][31:0] tab;
		logic [63:0] r;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bv;
		tab = '0;
		r = 64'd1 << 31;
		for (int i = 0; i < 16; i++) begin
			v = r << 30;
			res = '0;
			bv = 64'd1 << 62;
			for (int k = 0; k < 32; k++) begin
				if (bv > v)
					bv = bv >> 2;
			end
			for (int k = 0; k < 32; k++) begin
				if (bv != 0) begin
					if (v >= res + bv) begin
						v = v - (res + bv);
						res = (res >> 1) + bv;
					end else begin
						res = res >> 1;
					end
					bv = bv >> 2;
				end
			end
			r = res;
			tab[i] = r[31:0];
		end
		return tab;
	endfunction

	localparam logic [15:0][31:0] ROOT_TAB = root_table();

endpackage
`default_nettype wire

// ===== rtl/core/gspc_div.sv =====
// Restoring serial divider, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module gspc_div import gspc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire div_req_t          req,
	output logic                   done,
	output logic [DIV_NW-1:0]      quot
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] quo_q;

	logic [DIV_DW:0] r_sh;
	logic [DIV_DW:0] trial;
	logic            ge;

	// trial subtraction of the shifted remainder
	always_comb begin
		r_sh  = {rem_q, quo_q[DIV_NW-1]};
		ge    = r_sh >= {1'b0, den_q};
		trial = r_sh - {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == DIV_CW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], ge};
			rem_q <= ge ? trial[DIV_DW-1:0] : r_sh[DIV_DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/gas_sensor_ppm_converter.sv =====
// Top level: sample averaging, calibration and power-law ppm sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "gas_sensor_ppm_converter_assert.svh"
// A sample is taken on each transfer while the sequencer is idle. The first 100 samples
// build the clean-air baseline; the hundredth starts a calculation (serial divider, up
// to twice) during which s_tready is low, and gives no result. After that every tenth
// sample starts a calculation that can use the serial divider (twice), the shared 32x32
// multiplier for the log2 squaring loops (16 bits, twice) and the exp2 root products,
// plus a normalising shift of up to 35 bit positions per log. The other nine samples
// of a group are only accumulated. A result waits in the output register while samples
// go on being taken; a finished result stalls only if that register is still full.
module gas_sensor_ppm_converter import gspc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [11:0] sample_mv
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] ppm_q8
	output logic [1:0]       m_tuser    // [0] changed, [1] saturated
);

	typedef enum logic [20:0] {
		S_IDLE  = 21'h000001,
		S_TOP   = 21'h000002,
		S_DIFF  = 21'h000004,
		S_NUM   = 21'h000008,
		S_DIVA  = 21'h000010,
		S_DIVAW = 21'h000020,
		S_DIVR  = 21'h000040,
		S_DIVRW = 21'h000080,
		S_LGN   = 21'h000100,
		S_LGSQ  = 21'h000200,
		S_LGSQW = 21'h000400,
		S_SCL   = 21'h000800,
		S_SCLW  = 21'h001000,
		S_DIVB  = 21'h002000,
		S_DIVBW = 21'h004000,
		S_EXPM  = 21'h008000,
		S_EXPP  = 21'h010000,
		S_EXPL  = 21'h020000,
		S_EXPLW = 21'h040000,
		S_SHIFT = 21'h080000,
		S_OUT   = 21'h100000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [12:0] supply_q;
	logic [15:0] load_q;
	logic [15:0] ratio_q;
	logic [15:0] slope_q;
	logic [15:0] offset_q;
	logic        div_on_q;

	// block state
	logic [19:0] sum_q;
	logic [6:0]  cnt_q;
	logic        calibrated_q;
	logic [31:0] baseline_q;
	logic [31:0] last_q;

	// working registers
	logic [19:0] diff_q;
	logic [35:0] rs_q;
	logic [35:0] lg_x_q;
	logic [5:0]  lg_msb_q;
	logic [15:0] lg_frac_q;
	logic [31:0] y_q;
	logic [3:0]  it_q;
	logic        lg_second_q;
	logic [21:0] lga_q;
	logic [21:0] lgb_q;
	logic        neg_q;
	logic [24:0] d_q;
	logic [22:0] emag_q;
	logic [31:0] acc_q;
	logic [4:0]  k_q;
	logic [15:0] f_q;
	logic [31:0] res_q;
	logic        sat_q;
	logic [63:0] prod_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_ppm_q;
	logic        out_chg_q;
	logic        out_sat_q;

	// shared multiplier and divider
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	div_req_t    div_req;
	logic        div_done;
	logic [DIV_NW-1:0] div_quot;

	gspc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// APB port
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[4:2])
			REG_SUPPLY:  prdata = {19'd0, supply_q};
			REG_LOAD:    prdata = {16'd0, load_q};
			REG_RATIO:   prdata = {16'd0, ratio_q};
			REG_SLOPE:   prdata = {16'd0, slope_q};
			REG_OFFSET:  prdata = {16'd0, offset_q};
			REG_DIVIDER: prdata = {31'd0, div_on_q};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= 13'd5000;
			load_q   <= 16'd2560;
			ratio_q  <= 16'd2560;
			slope_q  <= 16'hF948;
			offset_q <= 16'd5325;
			div_on_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_SUPPLY:  supply_q <= pwdata[12:0];
				REG_LOAD:    load_q   <= pwdata[15:0];
				REG_RATIO:   ratio_q  <= pwdata[15:0];
				REG_SLOPE:   slope_q  <= pwdata[15:0];
				REG_OFFSET:  offset_q <= pwdata[15:0];
				REG_DIVIDER: div_on_q <= pwdata[0];
				default:     ;
			endcase
		end
	end

	// sample intake
	logic [12:0] samp;
	logic [19:0] sum_nx;
	logic [6:0]  cnt_nx;
	logic [6:0]  n_need;
	logic        s_xfer;

	assign s_tready = (state_q == S_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign samp     = div_on_q ? {s_tdata[11:0], 1'b0} : {1'b0, s_tdata[11:0]};
	assign sum_nx   = sum_q + 20'(samp);
	assign cnt_nx   = cnt_q + 1'b1;
	assign n_need   = calibrated_q ? 7'(GROUP_SAMPLES) : 7'(CALIB_SAMPLES);

	// combinational helpers of the sequencer
	logic [19:0] top;
	logic [22:0] l2;
	logic [22:0] l2_mag;
	logic [23:0] q_mag;
	logic [24:0] q_s;
	logic [24:0] b_x16;
	logic [24:0] d_mag;
	logic [16:0] m_mag;
	logic [32:0] sq;
	logic [21:0] lg_val;
	logic [15:0] frac_nx;
	logic [25:0] p_pos;
	logic [25:0] p_t;
	logic [26:0] p_val;
	logic [62:0] wide;

	always_comb begin
		top     = prod_q[19:0];
		l2      = {1'b0, lga_q} - {1'b0, lgb_q};
		l2_mag  = l2[22] ? (~l2 + 1'b1) : l2;
		q_mag   = neg_q ? 24'((prod_q[39:0] + 40'hFFFF) >> 16) : 24'(prod_q[39:16]);
		q_s     = neg_q ? (~{1'b0, q_mag} + 1'b1) : {1'b0, q_mag};
		b_x16   = {{5{offset_q[15]}}, offset_q, 4'b0};
		d_mag   = d_q[24] ? (~d_q + 1'b1) : d_q;
		m_mag   = slope_q[15] ? (~{1'b1, slope_q} + 1'b1) : {1'b0, slope_q};
		sq      = prod_q[63:31];
		frac_nx = lg_frac_q | (sq[32] ? (16'd1 << it_q) : 16'd0);
		lg_val  = {lg_msb_q, frac_nx};
		p_pos   = 26'(prod_q[40:16]) + 26'h80000;
		p_t     = 26'((prod_q[40:0] + 41'hFFFF) >> 16);
		p_val   = neg_q ? (27'h80000 - 27'(p_t)) : 27'(p_pos);
		wide    = {31'd0, acc_q} << k_q;
	end

	// multiplier operand selection
	always_comb begin
		unique case (state_q)
			S_TOP:   begin mul_a = 32'(supply_q); mul_b = 32'(n_need); end
			S_NUM:   begin mul_a = 32'(load_q);   mul_b = 32'(diff_q); end
			S_LGSQ:  begin mul_a = y_q;           mul_b = y_q; end
			S_SCL:   begin mul_a = 32'(l2_mag);   mul_b = 32'd19728; end
			S_EXPM:  begin mul_a = 32'(emag_q);   mul_b = 32'd217706; end
			S_EXPL:  begin mul_a = acc_q;         mul_b = ROOT_TAB[~it_q]; end
			default: begin mul_a = '0;            mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// divider requests
	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_DIVA: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NW'(prod_q[35:0]);
				div_req.den   = sum_q;
			end
			S_DIVR: begin
				div_req.start = 1'b1;
				div_req.num   = {rs_q, 8'd0};
				div_req.den   = DIV_DW'(ratio_q);
			end
			S_DIVB: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NW'({d_mag, 12'd0});
				div_req.den   = DIV_DW'(m_mag);
			end
			default: ;
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sum_q        <= '0;
			cnt_q        <= '0;
			calibrated_q <= 1'b0;
			baseline_q   <= '0;
			last_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// a new result may replace the one leaving in the same cycle
			if (state_q == S_OUT && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_xfer) begin
						sum_q <= sum_nx;
						cnt_q <= cnt_nx;
						if (cnt_nx >= n_need)
							state_q <= S_TOP;
					end
				end
				S_TOP: state_q <= S_DIFF;
				S_DIFF: begin
					if (!calibrated_q) begin
						if (sum_q == 20'd0 || ratio_q == 16'd0) begin
							baseline_q   <= SAT32;
							calibrated_q <= 1'b1;
							sum_q        <= '0;
							cnt_q        <= '0;
							state_q      <= S_IDLE;
						end else if (top <= sum_q) begin
							baseline_q   <= '0;
							calibrated_q <= 1'b1;
							sum_q        <= '0;
							cnt_q        <= '0;
							state_q      <= S_IDLE;
						end else begin
							state_q <= S_NUM;
						end
					end else if (sum_q == 20'd0 || top <= sum_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_NUM;
					end
				end
				S_NUM: state_q <= S_DIVA;
				S_DIVA: state_q <= S_DIVAW;
				S_DIVAW: begin
					if (div_done) begin
						if (!calibrated_q)
							state_q <= S_DIVR;
						else if (div_quot[35:0] == 36'd0 || slope_q == 16'd0)
							state_q <= S_OUT;
						else
							state_q <= S_LGN;
					end
				end
				S_DIVR: state_q <= S_DIVRW;
				S_DIVRW: begin
					if (div_done) begin
						baseline_q   <= (|div_quot[43:32]) ? SAT32 : div_quot[31:0];
						calibrated_q <= 1'b1;
						sum_q        <= '0;
						cnt_q        <= '0;
						state_q      <= S_IDLE;
					end
				end
				S_LGN: begin
					if (lg_x_q[35])
						state_q <= S_LGSQ;
				end
				S_LGSQ: state_q <= S_LGSQW;
				S_LGSQW: begin
					if (it_q != 4'd0)
						state_q <= S_LGSQ;
					else if (!lg_second_q)
						state_q <= S_LGN;
					else
						state_q <= S_SCL;
				end
				S_SCL: state_q <= S_SCLW;
				S_SCLW: state_q <= S_DIVB;
				S_DIVB: state_q <= S_DIVBW;
				S_DIVBW: begin
					if (div_done)
						state_q <= S_EXPM;
				end
				S_EXPM: state_q <= S_EXPP;
				S_EXPP: begin
					if (p_val[26] || (|p_val[25:21]))
						state_q <= S_OUT;
					else
						state_q <= S_EXPL;
				end
				S_EXPL: state_q <= S_EXPLW;
				S_EXPLW: begin
					if (it_q == 4'd0)
						state_q <= S_SHIFT;
					else
						state_q <= S_EXPL;
				end
				S_SHIFT: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || m_tready) begin
						last_q      <= res_q;
						sum_q       <= '0;
						cnt_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_DIFF: begin
				diff_q <= top - sum_q;
				res_q  <= SAT32;
				sat_q  <= 1'b1;
			end
			S_DIVAW: begin
				rs_q        <= div_quot[35:0];
				lg_x_q      <= div_quot[35:0];
				lg_msb_q    <= 6'd35;
				lg_second_q <= 1'b0;
				res_q       <= SAT32;
				sat_q       <= 1'b1;
			end
			S_LGN: begin
				// normalise to the top bit, then take the Q31 mantissa
				if (lg_x_q[35]) begin
					y_q       <= lg_x_q[35:4];
					it_q      <= 4'd15;
					lg_frac_q <= '0;
				end else begin
					lg_x_q   <= {lg_x_q[34:0], 1'b0};
					lg_msb_q <= lg_msb_q - 1'b1;
				end
			end
			S_LGSQW: begin
				y_q       <= sq[32] ? sq[32:1] : sq[31:0];
				lg_frac_q <= frac_nx;
				it_q      <= it_q - 1'b1;
				if (it_q == 4'd0) begin
					if (!lg_second_q) begin
						lga_q       <= lg_val;
						lg_x_q      <= (baseline_q != 32'd0) ? {4'd0, baseline_q} : 36'd256;
						lg_msb_q    <= 6'd35;
						lg_second_q <= 1'b1;
					end else begin
						lgb_q <= lg_val;
					end
				end
			end
			S_SCL: neg_q <= l2[22];
			S_SCLW: d_q <= q_s - b_x16;
			S_DIVB: neg_q <= d_q[24] ^ slope_q[15];
			S_DIVBW: emag_q <= (|div_quot[43:22]) ? 23'h400000 : div_quot[22:0];
			S_EXPP: begin
				// exponent out of range saturates, negative gives zero
				k_q   <= p_val[20:16];
				f_q   <= p_val[15:0];
				acc_q <= 32'h4000_0000;
				it_q  <= 4'd15;
				res_q <= p_val[26] ? 32'd0 : SAT32;
				sat_q <= !p_val[26];
			end
			S_EXPLW: begin
				if (f_q[it_q])
					acc_q <= prod_q[61:30];
				it_q <= it_q - 1'b1;
			end
			S_SHIFT: begin
				res_q <= wide[62] ? SAT32 : wide[61:30];
				sat_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || m_tready)) begin
			out_ppm_q <= res_q;
			out_chg_q <= res_q != last_q;
			out_sat_q <= sat_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_ppm_q;
	assign m_tuser  = {out_sat_q, out_chg_q};

	// checks
	`GSPC_ASSERT(a_out_from_seq, $rose(m_tvalid) |-> $past(state_q == S_OUT), "result without sequencer")
	`GSPC_NEVER(a_div_waited, div_done && !(state_q == S_DIVAW || state_q == S_DIVRW || state_q == S_DIVBW), "divider done unawaited")
	`GSPC_ASSERT(a_calib_sticky, calibrated_q |=> calibrated_q, "calibration lost")
	`GSPC_ASSERT(a_sat_max, (m_tvalid && m_tuser[1]) |-> (m_tdata == SAT32), "saturated but not max")

endmodule
`default_nettype wire
